>>> src/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the palette color mapper.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int unsigned PALETTE_DEPTH_DEF = 256;
    localparam int unsigned SUM_W   = 40;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned DIST_W  = 18;
    localparam int unsigned IDX_W   = 8;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_MAP    = 2'd1;
    localparam logic [1:0] KIND_SMOOTH = 2'd2;

    localparam logic [0:0] REG_PALETTE_SIZE = 1'd0;
    localparam logic [0:0] REG_SMOOTH_WGT   = 1'd1;

    localparam logic RES_MAP    = 1'b0;
    localparam logic RES_SMOOTH = 1'b1;

    // Divider request/response between sequencer and divider.
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] quot;
    } div_rsp_t;

endpackage

>>> src/pcm_divider.sv
// ----------------------------------------------------------------------------
// pcm_divider
// Restoring divider, one quotient bit per cycle, saturated to 8 bits.
// ----------------------------------------------------------------------------
module pcm_divider
    import pcm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [CNT_W:0]    trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
        if (req.start) begin
            quot_next = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        if (req.start) begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (quot_reg > SUM_W'(255)) ? 8'd255 : quot_reg[COLOR_W-1:0];

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg != '0) else $error("divider step count ran out");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("divider did not start");

endmodule

>>> src/palette_color_mapper.sv
// ----------------------------------------------------------------------------
// palette_color_mapper
// Nearest palette color search with running-average palette smoothing.
// ----------------------------------------------------------------------------
// Map word: one palette entry read per cycle through one shared distance
//   unit; with smoothing on, the chosen entry's sums and count are updated.
//   Load word: the entry is written, then the block is idle again.
// Smooth word: three channels in turn on one bit-serial divider; no division
//   when the count is zero or smoothing is off. One word at a time.
// aresetn (sync, active low) resets control state and config registers; data registers and memories hold.
module palette_color_mapper
    import pcm_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [31:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: palette_index[7:0], out_red[15:8], out_green[23:16], out_blue[31:24]
    output logic [31:0] m_tdata,
    // tuser: result_kind
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);
    localparam int unsigned NW = AW + 1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_LOAD   = 10'b0000000010,
        ST_SCAN   = 10'b0000000100,
        ST_ACC_RD = 10'b0000001000,
        ST_ACC_WR = 10'b0000010000,
        ST_SM_RD  = 10'b0000100000,
        ST_SM_DIV = 10'b0001000000,
        ST_SM_WR  = 10'b0010000000,
        ST_RESULT = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    // Storage
    logic [23:0]      pal_mem [PALETTE_DEPTH];
    logic [SUM_W-1:0] r_mem   [PALETTE_DEPTH];
    logic [SUM_W-1:0] g_mem   [PALETTE_DEPTH];
    logic [SUM_W-1:0] b_mem   [PALETTE_DEPTH];
    logic [CNT_W-1:0] c_mem   [PALETTE_DEPTH];

    state_t state_reg, state_next;
    logic [8:0]  psize_reg;
    logic [7:0]  wgt_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  rin_reg, gin_reg, bin_reg;
    logic [AW-1:0] addr_reg, best_reg, tag_reg;
    logic [NW-1:0] rcnt_reg, scan_n;
    logic        pv_reg;
    logic [23:0] pal_rd;
    logic [SUM_W-1:0] r_rd, g_rd, b_rd;
    logic [CNT_W-1:0] c_rd;
    logic [DIST_W-1:0] dmin_reg, dist_val;
    logic        first_reg;
    logic [1:0]  ch_reg;
    logic [23:0] mean_reg;
    logic        m_valid_reg, m_kind_reg;
    logic [31:0] m_data_reg;
    logic [AW-1:0] idx_w;
    logic [7:0]  wm1;
    logic [15:0] r_seed, g_seed, b_seed;
    logic [AW-1:0] rd_addr;
    logic        pal_we, acc_we;
    logic [AW-1:0] wr_addr;
    logic [23:0] pal_wd;
    logic [SUM_W-1:0] r_wd, g_wd, b_wd;
    logic [CNT_W-1:0] c_wd;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // Wrap the entry index into the palette: subtract shifted copies of the
    // depth, largest first; nothing is subtracted when the depth covers 8 bits.
    function automatic logic [AW-1:0] wrap_index(input logic [7:0] v);
        logic [19:0] r;
        r = {12'd0, v};
        for (int k = 7; k >= 0; k--) begin
            if (r >= (20'(PALETTE_DEPTH) << k)) begin
                r = r - (20'(PALETTE_DEPTH) << k);
            end
        end
        return AW'(r);
    endfunction

    assign idx_w = wrap_index(s_tdata[7:0]);
    assign wm1   = (wgt_reg != 8'd0) ? wgt_reg - 8'd1 : 8'd0;
    assign scan_n = (psize_reg == 9'd0) ? NW'(1) :
                    ({23'd0, psize_reg} > 32'(PALETTE_DEPTH)) ? NW'(PALETTE_DEPTH) :
                    NW'(psize_reg);

    // Seed sums on load: color times (weight - 1, or zero when the weight is zero), an 8 by 8 product.
    assign r_seed = {8'd0, rin_reg} * {8'd0, wm1};
    assign g_seed = {8'd0, gin_reg} * {8'd0, wm1};
    assign b_seed = {8'd0, bin_reg} * {8'd0, wm1};

    // Accept a new word only when idle and the output register is free.
    assign s_tready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid_reg;

    pcm_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Shared distance unit on the entry read last cycle.
    function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? a - b : b - a;
        return 16'(d) * 16'(d);
    endfunction
    assign dist_val = DIST_W'(sqd(rin_reg, pal_rd[23:16]))
                    + DIST_W'(sqd(gin_reg, pal_rd[15:8]))
                    + DIST_W'(sqd(bin_reg, pal_rd[7:0]));

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [7:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(v);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // Memory read address: scan counter, chosen entry, or addressed entry.
    always_comb begin
        priority case (1'b1)
            state_reg == ST_SCAN:   rd_addr = addr_reg;
            state_reg == ST_RESULT: rd_addr = best_reg;
            default:                rd_addr = best_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        pal_rd <= pal_mem[rd_addr];
        r_rd   <= r_mem[rd_addr];
        g_rd   <= g_mem[rd_addr];
        b_rd   <= b_mem[rd_addr];
        c_rd   <= c_mem[rd_addr];
        if (pal_we) begin
            pal_mem[wr_addr] <= pal_wd;
        end
        if (acc_we) begin
            r_mem[wr_addr] <= r_wd;
            g_mem[wr_addr] <= g_wd;
            b_mem[wr_addr] <= b_wd;
            c_mem[wr_addr] <= c_wd;
        end
    end

    // Write side
    always_comb begin
        pal_we  = 1'b0;
        acc_we  = 1'b0;
        wr_addr = best_reg;
        pal_wd  = {rin_reg, gin_reg, bin_reg};
        r_wd    = SUM_W'(r_seed);
        g_wd    = SUM_W'(g_seed);
        b_wd    = SUM_W'(b_seed);
        c_wd    = CNT_W'(wm1);
        if (state_reg == ST_LOAD) begin
            pal_we = 1'b1;
            acc_we = 1'b1;
        end else if (state_reg == ST_ACC_WR) begin
            acc_we = 1'b1;
            r_wd   = sat_sum(r_rd, rin_reg);
            g_wd   = sat_sum(g_rd, gin_reg);
            b_wd   = sat_sum(b_rd, bin_reg);
            c_wd   = (c_rd == '1) ? c_rd : c_rd + 1'b1;
        end else if (state_reg == ST_SM_WR) begin
            pal_we = 1'b1;
            pal_wd = mean_reg;
        end
    end

    // Divider feed: one channel at a time, red then green then blue.
    always_comb begin
        dreq.start    = 1'b0;
        dreq.divisor  = c_rd;
        dreq.dividend = (ch_reg == 2'd0) ? r_rd : (ch_reg == 2'd1) ? g_rd : b_rd;
        if (state_reg == ST_SM_RD && pv_reg) begin
            dreq.start = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    unique case (s_tuser)
                        KIND_LOAD:   state_next = ST_LOAD;
                        KIND_MAP:    state_next = ST_SCAN;
                        KIND_SMOOTH: state_next = ST_SM_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_SCAN: begin
                if (!pv_reg && rcnt_reg == '0 && !first_reg) begin
                    state_next = (wgt_reg != 8'd0) ? ST_ACC_RD : ST_RESULT;
                end
            end
            ST_ACC_RD: state_next = pv_reg ? ST_ACC_WR : ST_ACC_RD;
            ST_ACC_WR: state_next = ST_RESULT;
            ST_SM_RD: begin
                if (pv_reg) begin
                    state_next = (wgt_reg != 8'd0 && c_rd != '0) ? ST_SM_DIV : ST_RESULT;
                end
            end
            ST_SM_DIV: begin
                if (drsp.done) begin
                    state_next = (ch_reg == 2'd2) ? ST_SM_WR : ST_SM_RD;
                end
            end
            ST_SM_WR:  state_next = ST_RESULT;
            ST_RESULT: state_next = pv_reg ? ST_OUT : ST_RESULT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            psize_reg   <= 9'd256;
            wgt_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
            rcnt_reg    <= '0;
            first_reg   <= 1'b0;
            ch_reg      <= 2'd0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PALETTE_SIZE) psize_reg <= cfg_data;
                else                               wgt_reg   <= cfg_data[7:0];
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    pv_reg <= 1'b0;
                    ch_reg <= 2'd0;
                    if (s_tvalid && s_tready && s_tuser == KIND_MAP) begin
                        rcnt_reg  <= scan_n;
                        first_reg <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    // flag the read issued this cycle as valid next cycle
                    pv_reg <= (rcnt_reg != '0);
                    if (rcnt_reg != '0) begin
                        rcnt_reg <= rcnt_reg - 1'b1;
                    end
                    if (pv_reg) first_reg <= 1'b0;
                end
                ST_ACC_RD, ST_SM_RD, ST_RESULT: pv_reg <= !pv_reg;
                ST_SM_DIV: begin
                    pv_reg <= 1'b0;
                    if (drsp.done) ch_reg <= ch_reg + 2'd1;
                end
                ST_OUT: begin
                    pv_reg      <= 1'b0;
                    m_valid_reg <= 1'b1;
                end
                default: pv_reg <= 1'b0;
            endcase
        end
        // Payload
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            rin_reg  <= s_tdata[15:8];
            gin_reg  <= s_tdata[23:16];
            bin_reg  <= s_tdata[31:24];
            best_reg <= idx_w;
            addr_reg <= '0;
            tag_reg  <= '0;
        end
        if (state_reg == ST_SCAN) begin
            if (rcnt_reg != '0) addr_reg <= addr_reg + 1'b1;
            if (pv_reg) begin
                tag_reg <= tag_reg + 1'b1;
                if (first_reg || dist_val < dmin_reg) begin
                    dmin_reg <= dist_val;
                    best_reg <= tag_reg;
                end
            end
        end
        if (state_reg == ST_SM_DIV && drsp.done) begin
            unique case (ch_reg)
                2'd0:    mean_reg[23:16] <= drsp.quot;
                2'd1:    mean_reg[15:8]  <= drsp.quot;
                default: mean_reg[7:0]   <= drsp.quot;
            endcase
        end
        if (state_reg == ST_OUT) begin
            m_kind_reg <= (kind_reg == KIND_SMOOTH) ? RES_SMOOTH : RES_MAP;
            m_data_reg <= {pal_rd[7:0], pal_rd[15:8], pal_rd[23:16], 8'(best_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg) else $error("result dropped");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> rcnt_reg <= scan_n) else $error("scan count overrun");
    a_div_only_smooth: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |-> kind_reg == KIND_SMOOTH) else $error("divider used outside smooth");

endmodule

>>> tb/sv/tb_palette_color_mapper.sv
// ----------------------------------------------------------------------------
// tb_palette_color_mapper
// Self-checking testbench of the palette color mapper: a scoreboard predicts
// every map and smooth word from its own copy of palette, sums and counts,
// and compares each result word field by field. Directed words come first,
// then random phases under varying palette size, smoothing weight and idling.
// ----------------------------------------------------------------------------
module tb_palette_color_mapper;
    import pcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 256;
    localparam int          DRAIN_WAIT  = 300;      // longer than a smooth word
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam logic [39:0] SUM_MAX     = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
    localparam logic [1:0]  KIND_NONE   = 2'd3;     // unused kind, dropped by the block

    typedef struct {
        logic       res_kind;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_word_t;

    // Holds the palette state and predicts the result word of every map and smooth word.
    class palette_scoreboard;
        logic [7:0]  pal_r[DEPTH];
        logic [7:0]  pal_g[DEPTH];
        logic [7:0]  pal_b[DEPTH];
        logic [39:0] sum_r[DEPTH];
        logic [39:0] sum_g[DEPTH];
        logic [39:0] sum_b[DEPTH];
        logic [31:0] hits[DEPTH];
        logic [8:0]  size_reg = 9'd256;
        logic [7:0]  weight_reg = 8'd0;
        color_word_t pending[$];
        int          errors = 0;

        function void write_reg(logic idx, logic [8:0] val);
            if (idx == REG_PALETTE_SIZE)
                size_reg = val;
            else
                weight_reg = val[7:0];
        endfunction

        function logic [39:0] sat_sum(logic [39:0] a, logic [7:0] b);
            logic [40:0] s;
            s = {1'b0, a} + 41'(b);
            return (s > 41'(SUM_MAX)) ? SUM_MAX : s[39:0];
        endfunction

        function logic [7:0] mean8(logic [39:0] s, logic [31:0] c);
            logic [39:0] q;
            q = s / 40'(c);
            return (q > 40'd255) ? 8'd255 : q[7:0];
        endfunction

        function void note_word(logic [1:0] kind, logic [7:0] idx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
            color_word_t w;
            int unsigned n, best, dmin, d;
            int          dr, dg, db;
            logic [7:0]  seed;
            seed = (weight_reg > 8'd0) ? weight_reg - 8'd1 : 8'd0;
            case (kind)
                KIND_LOAD: begin
                    pal_r[idx] = r;
                    pal_g[idx] = g;
                    pal_b[idx] = b;
                    sum_r[idx] = 40'(r) * 40'(seed);
                    sum_g[idx] = 40'(g) * 40'(seed);
                    sum_b[idx] = 40'(b) * 40'(seed);
                    hits[idx]  = 32'(seed);
                end
                KIND_MAP: begin
                    n = 32'(size_reg);
                    if (n < 1) n = 1;
                    if (n > DEPTH) n = DEPTH;
                    best = 0;
                    dmin = 0;
                    for (int i = 0; i < n; i++) begin
                        dr = int'(r) - int'(pal_r[i]);
                        dg = int'(g) - int'(pal_g[i]);
                        db = int'(b) - int'(pal_b[i]);
                        d  = unsigned'(dr * dr + dg * dg + db * db);
                        // strict compare: ties keep the lower index
                        if (i == 0 || d < dmin) begin
                            dmin = d;
                            best = i;
                        end
                    end
                    if (weight_reg > 8'd0) begin
                        if (hits[best] != CNT_MAX) hits[best] = hits[best] + 32'd1;
                        sum_r[best] = sat_sum(sum_r[best], r);
                        sum_g[best] = sat_sum(sum_g[best], g);
                        sum_b[best] = sat_sum(sum_b[best], b);
                    end
                    w = '{RES_MAP, best[7:0], pal_r[best], pal_g[best], pal_b[best]};
                    pending.push_back(w);
                end
                KIND_SMOOTH: begin
                    // zero weight or zero count keeps the entry as it is
                    if (weight_reg > 8'd0 && hits[idx] != 0) begin
                        pal_r[idx] = mean8(sum_r[idx], hits[idx]);
                        pal_g[idx] = mean8(sum_g[idx], hits[idx]);
                        pal_b[idx] = mean8(sum_b[idx], hits[idx]);
                    end
                    w = '{RES_SMOOTH, idx, pal_r[idx], pal_g[idx], pal_b[idx]};
                    pending.push_back(w);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic res_kind, logic [31:0] data);
            color_word_t w;
            if (pending.size() == 0) begin
                $error("unexpected result word: kind %0d data %h", res_kind, data);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (res_kind !== w.res_kind) begin
                $error("result_kind: expected %0d actual %0d", w.res_kind, res_kind);
                errors++;
            end
            if (data[7:0] !== w.index) begin
                $error("palette_index: expected %0d actual %0d", w.index, data[7:0]);
                errors++;
            end
            if (data[15:8] !== w.red) begin
                $error("out_red: expected %0d actual %0d", w.red, data[15:8]);
                errors++;
            end
            if (data[23:16] !== w.green) begin
                $error("out_green: expected %0d actual %0d", w.green, data[23:16]);
                errors++;
            end
            if (data[31:24] !== w.blue) begin
                $error("out_blue: expected %0d actual %0d", w.blue, data[31:24]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    palette_scoreboard sb = new();
    bit                idle_on = 1'b1;  // random gaps on both sides when set
    longint            cycles = 0;

    palette_color_mapper dut (.*);

    always #4 aclk = ~aclk;

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: stall for a random number of cycles, then take one word.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_word(m_tuser, m_tdata);
        end
    end

    // Send one input word; hold it until the block takes it.
    task automatic send_word(logic [1:0] kind, logic [7:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {b, g, r, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(kind, idx, r, g, b);
    endtask

    // Wait until every expected word is back and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int words);
        int          pick;
        logic [7:0]  idx;
        logic [1:0]  kind;
        for (int k = 0; k < words; k++) begin
            pick = $urandom_range(0, 99);
            idx  = 8'($urandom_range(0, 255));
            if (pick < 15) begin
                // a random tenth of the loads copy another entry to force distance ties
                if ($urandom_range(0, 9) == 0)
                    send_word(KIND_LOAD, idx, sb.pal_r[idx ^ 8'h5a],
                              sb.pal_g[idx ^ 8'h5a], sb.pal_b[idx ^ 8'h5a]);
                else
                    send_word(KIND_LOAD, idx, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 75) begin
                if ($urandom_range(0, 7) == 0)
                    send_word(KIND_MAP, idx, sb.pal_r[idx], sb.pal_g[idx], sb.pal_b[idx]);
                else
                    send_word(KIND_MAP, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
            end else if (pick < 95) begin
                send_word(KIND_SMOOTH, idx, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                kind = KIND_NONE;
                send_word(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [8:0] size_val;
        logic [8:0] wgt_val;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PALETTE_SIZE;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-entry palette, smoothing off; size zero acts as one.
        write_reg(REG_PALETTE_SIZE, 9'd1);
        write_reg(REG_SMOOTH_WGT, 9'd0);
        send_word(KIND_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(KIND_MAP, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(KIND_SMOOTH, 8'd0, 8'hff, 8'hff, 8'hff);
        drain();
        write_reg(REG_PALETTE_SIZE, 9'd0);
        send_word(KIND_MAP, 8'd0, 8'd1, 8'd2, 8'd3);
        send_word(KIND_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
        drain();

        // Weight one seeds zero counts; entries 1 and 2 tie.
        write_reg(REG_SMOOTH_WGT, 9'd1);
        write_reg(REG_PALETTE_SIZE, 9'd3);
        send_word(KIND_LOAD, 8'd1, 8'hff, 8'hff, 8'hff);
        send_word(KIND_LOAD, 8'd2, 8'hff, 8'hff, 8'hff);
        send_word(KIND_SMOOTH, 8'd2, 8'd0, 8'd0, 8'd0);
        send_word(KIND_MAP, 8'd0, 8'hff, 8'hff, 8'hff);
        send_word(KIND_MAP, 8'd0, 8'hc0, 8'hf0, 8'h90);
        send_word(KIND_MAP, 8'd0, 8'h80, 8'h80, 8'h80);
        send_word(KIND_SMOOTH, 8'd1, 8'd0, 8'd0, 8'd0);
        send_word(KIND_MAP, 8'd0, 8'hf0, 8'h0f, 8'haa);
        send_word(KIND_SMOOTH, 8'd1, 8'd0, 8'd0, 8'd0);
        drain();

        // Largest weight, then fill the whole palette so any size is legal.
        write_reg(REG_SMOOTH_WGT, 9'd255);
        write_reg(REG_PALETTE_SIZE, 9'd511);
        for (int i = 0; i < DEPTH; i++)
            send_word(KIND_LOAD, i[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
        send_word(KIND_MAP, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(KIND_MAP, 8'd0, 8'hff, 8'hff, 8'hff);
        send_word(KIND_SMOOTH, 8'd255, 8'd0, 8'd0, 8'd0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 4))
                0:       size_val = 9'd1;
                1:       size_val = 9'd256;
                2:       size_val = 9'd0;
                3:       size_val = 9'd511;
                default: size_val = 9'($urandom_range(1, 256));
            endcase
            case ($urandom_range(0, 3))
                0:       wgt_val = 9'd0;
                1:       wgt_val = 9'd1;
                2:       wgt_val = 9'd255;
                default: wgt_val = 9'($urandom_range(0, 255));
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            write_reg(REG_PALETTE_SIZE, size_val);
            write_reg(REG_SMOOTH_WGT, wgt_val);
            random_phase(110);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
src/pcm_pkg.sv
src/pcm_divider.sv
src/palette_color_mapper.sv
tb/sv/tb_palette_color_mapper.sv
